// ===== rtl/sdfs_pkg.sv =====
`timescale 1ns / 1ps

package sdfs_pkg;

  localparam int MAX_KEPT_DEF  = 16;
  localparam int MAX_SLOTS_DEF = 64;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int SLOT_CMP_W  = 9;
  localparam int MINUTES_W   = 14;

  localparam logic [7:0] DAILY_CODE   = 8'd0;
  localparam logic [7:0] WEEKLY_LO    = 8'd51;
  localparam logic [7:0] WEEKLY_HI    = 8'd57;
  localparam logic [7:0] WEEKLY_BASE  = 8'd50;
  localparam logic [7:0] YEARLY_LO    = 8'd101;
  localparam logic [7:0] YEARLY_HI    = 8'd131;
  localparam logic [7:0] YEARLY_BASE  = 8'd100;
  localparam logic [3:0] DAYS_IN_WEEK = 4'd7;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;

  localparam logic [4:0] TODAY_DAY_RST     = 5'd1;
  localparam logic [3:0] TODAY_MONTH_RST   = 4'd1;
  localparam logic [2:0] TODAY_WEEKDAY_RST = 3'd0;
  localparam logic [4:0] NEXT_DAY_RST      = 5'd2;
  localparam logic [3:0] NEXT_MONTH_RST    = 4'd1;
  localparam logic [7:0] END_CODE_RST      = 8'd255;
  localparam logic [7:0] INACTIVE_CODE_RST = 8'd0;
  localparam logic [7:0] REMIND_CODE_RST   = 8'd2;

  typedef enum logic [2:0] {
    REG_TODAY_DAY     = 3'd0,
    REG_TODAY_MONTH   = 3'd1,
    REG_TODAY_WEEKDAY = 3'd2,
    REG_NEXT_DAY      = 3'd3,
    REG_NEXT_MONTH    = 3'd4,
    REG_END_CODE      = 3'd5,
    REG_INACTIVE_CODE = 3'd6,
    REG_REMIND_CODE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] today_day;
    logic [3:0] today_month;
    logic [2:0] today_weekday;
    logic [4:0] next_day;
    logic [3:0] next_month;
    logic [7:0] end_code;
    logic [7:0] inactive_code;
    logic [7:0] remind_code;
  } cfg_t;

  // hour in the lowest bits, slot in the highest
  typedef struct packed {
    logic [5:0] slot;
    logic [7:0] subject;
    logic [7:0] flags;
    logic [7:0] category;
    logic [7:0] month;
    logic [7:0] day_code;
    logic [7:0] minute;
    logic [7:0] hour;
  } record_t;

  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic       tomorrow;
    logic [7:0] flags;
    logic [7:0] category;
    logic [7:0] subject;
    logic [5:0] slot;
  } entry_t;

  typedef struct packed {
    logic rec_load;
    logic wr_today;
    logic wr_tom;
    logic rd_en;
    logic cur_load;
    logic cmp_step;
    logic wb;
    logic out_load;
    logic out_empty;
    logic out_last;
    logic count_clr;
  } cmd_t;

  typedef struct packed {
    logic end_scan;
    logic m_today;
    logic m_tom;
    logic last;
    logic rec_tom;
    logic rec_last;
    logic full;
  } sts_t;

  function automatic logic [MINUTES_W-1:0] minutes(input logic [7:0] hour,
                                                  input logic [7:0] minute);
    logic [MINUTES_W-1:0] prod;
    prod = MINUTES_W'(hour) * MINUTES_W'(MIN_PER_HOUR);
    return prod + MINUTES_W'(minute);
  endfunction

endpackage

// ===== rtl/schedule_day_filter_sort_core.sv =====
// Schedule filter: takes one stored record per transaction, keeps those due
// today (and day-before reminders whose flag equals the remind code) in a
// small entry memory, and on the end marker, a record marked tlast or the
// last slot, sorts the kept entries (today before reminders, then by time
// of day) and streams them out, tlast on the final one. An empty list
// gives one transaction with list_empty and tlast set and all other fields zero.
// Each record but an end marker is handled in the accept cycle, which
// also writes a today entry, and then in S_TOM for a reminder write.
// The sort walks the entry memory: each position is loaded, compared with
// every later entry, swapped as needed and written back. Each entry is
// then read, loaded and presented, plus any wait on out_tready. No input
// is taken while the sort or the list output is in progress.
`timescale 1ns / 1ps

module schedule_day_filter_sort_core #(
  parameter int MAX_KEPT  = sdfs_pkg::MAX_KEPT_DEF,
  parameter int MAX_SLOTS = sdfs_pkg::MAX_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // rec_hour, rec_minute, day_code, rec_month, category_byte, flag_byte,
  // subject_byte, slot_index, zero pad
  input  logic [sdfs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_hour, out_minute, out_flags, out_category, out_subject, out_slot,
  // zero pad
  output logic [sdfs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // is_tomorrow, list_empty
  output logic [sdfs_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdfs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sdfs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sdfs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int RW = $bits(sdfs_pkg::record_t);

  sdfs_pkg::cfg_t    cfg;
  sdfs_pkg::record_t in_rec;
  sdfs_pkg::cmd_t    cmd;
  sdfs_pkg::sts_t    sts;
  sdfs_pkg::entry_t  out_entry;
  logic [CW-1:0]     kept_count;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              out_empty;
  logic              out_last;

  assign in_rec = sdfs_pkg::record_t'(in_tdata[RW-1:0]);

  sdfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdfs_ctrl #(
    .MAX_KEPT (MAX_KEPT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .kept_count (kept_count),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  sdfs_dp #(
    .MAX_KEPT  (MAX_KEPT),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_rec     (in_rec),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .sts        (sts),
    .kept_count (kept_count),
    .out_entry  (out_entry),
    .out_empty  (out_empty),
    .out_last   (out_last)
  );

  assign out_tdata = {2'b00, out_entry.slot, out_entry.subject, out_entry.category,
                      out_entry.flags, out_entry.minute, out_entry.hour};
  assign out_tuser = {out_empty, out_entry.tomorrow};
  assign out_tlast = out_last;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open at once");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_count <= CW'(MAX_KEPT))
    else $error("kept count beyond store size");

  a_clear_after_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> kept_count == '0)
    else $error("kept count not cleared after list");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && out_tlast && !out_tuser[0])
    else $error("empty list transaction carries data");

endmodule

// ===== rtl/sdfs_cfg.sv =====
`timescale 1ns / 1ps

module sdfs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sdfs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sdfs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sdfs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output sdfs_pkg::cfg_t                     cfg
);

  sdfs_pkg::cfg_t   cfg_r;
  sdfs_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = sdfs_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.today_day     <= sdfs_pkg::TODAY_DAY_RST;
      cfg_r.today_month   <= sdfs_pkg::TODAY_MONTH_RST;
      cfg_r.today_weekday <= sdfs_pkg::TODAY_WEEKDAY_RST;
      cfg_r.next_day      <= sdfs_pkg::NEXT_DAY_RST;
      cfg_r.next_month    <= sdfs_pkg::NEXT_MONTH_RST;
      cfg_r.end_code      <= sdfs_pkg::END_CODE_RST;
      cfg_r.inactive_code <= sdfs_pkg::INACTIVE_CODE_RST;
      cfg_r.remind_code   <= sdfs_pkg::REMIND_CODE_RST;
    end else if (wr_en) begin
      case (idx)
        sdfs_pkg::REG_TODAY_DAY:     cfg_r.today_day     <= pwdata[4:0];
        sdfs_pkg::REG_TODAY_MONTH:   cfg_r.today_month   <= pwdata[3:0];
        sdfs_pkg::REG_TODAY_WEEKDAY: cfg_r.today_weekday <= pwdata[2:0];
        sdfs_pkg::REG_NEXT_DAY:      cfg_r.next_day      <= pwdata[4:0];
        sdfs_pkg::REG_NEXT_MONTH:    cfg_r.next_month    <= pwdata[3:0];
        sdfs_pkg::REG_END_CODE:      cfg_r.end_code      <= pwdata[7:0];
        sdfs_pkg::REG_INACTIVE_CODE: cfg_r.inactive_code <= pwdata[7:0];
        sdfs_pkg::REG_REMIND_CODE:   cfg_r.remind_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      sdfs_pkg::REG_TODAY_DAY:     prdata = 32'(cfg_r.today_day);
      sdfs_pkg::REG_TODAY_MONTH:   prdata = 32'(cfg_r.today_month);
      sdfs_pkg::REG_TODAY_WEEKDAY: prdata = 32'(cfg_r.today_weekday);
      sdfs_pkg::REG_NEXT_DAY:      prdata = 32'(cfg_r.next_day);
      sdfs_pkg::REG_NEXT_MONTH:    prdata = 32'(cfg_r.next_month);
      sdfs_pkg::REG_END_CODE:      prdata = 32'(cfg_r.end_code);
      sdfs_pkg::REG_INACTIVE_CODE: prdata = 32'(cfg_r.inactive_code);
      sdfs_pkg::REG_REMIND_CODE:   prdata = 32'(cfg_r.remind_code);
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sdfs_dp.sv =====
`timescale 1ns / 1ps

module sdfs_dp #(
  parameter int MAX_KEPT  = sdfs_pkg::MAX_KEPT_DEF,
  parameter int MAX_SLOTS = sdfs_pkg::MAX_SLOTS_DEF,
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  localparam int CW = $clog2(MAX_KEPT + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sdfs_pkg::cfg_t    cfg,
  input  sdfs_pkg::record_t in_rec,
  input  logic              in_last,
  input  sdfs_pkg::cmd_t    cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  output sdfs_pkg::sts_t    sts,
  output logic [CW-1:0]     kept_count,
  output sdfs_pkg::entry_t  out_entry,
  output logic              out_empty,
  output logic              out_last
);

  localparam int SW = sdfs_pkg::SLOT_CMP_W;

  sdfs_pkg::entry_t  mem [MAX_KEPT];
  sdfs_pkg::entry_t  rdata_r;
  sdfs_pkg::entry_t  cur_r;
  sdfs_pkg::entry_t  out_entry_r;
  sdfs_pkg::record_t rec_r;
  logic              rec_tom_r;
  logic              rec_last_r;
  logic              out_empty_r;
  logic              out_last_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  logic [7:0]        code;
  logic              weekly;
  logic              yearly;
  logic [2:0]        wd;
  logic [3:0]        wd_today;
  logic [3:0]        wd_wrap;
  logic [3:0]        wd_tom;
  logic [7:0]        dom;
  logic              date_today;
  logic              date_tom;
  logic              hit_today;
  logic              hit_tom;
  logic              active;
  logic [SW-1:0]     slot_ext;

  logic              we;
  logic [AW-1:0]     waddr;
  sdfs_pkg::entry_t  wdata;
  logic              swap;

  assign code     = in_rec.day_code;
  assign weekly   = code inside {[sdfs_pkg::WEEKLY_LO:sdfs_pkg::WEEKLY_HI]};
  assign yearly   = code inside {[sdfs_pkg::YEARLY_LO:sdfs_pkg::YEARLY_HI]};
  assign wd       = 3'(code - sdfs_pkg::WEEKLY_BASE);
  assign wd_today = {1'b0, cfg.today_weekday} + 4'd1;
  assign wd_wrap  = (wd_today >= sdfs_pkg::DAYS_IN_WEEK) ?
                    wd_today - sdfs_pkg::DAYS_IN_WEEK : wd_today;
  assign wd_tom   = wd_wrap + 4'd1;
  assign dom      = yearly ? code - sdfs_pkg::YEARLY_BASE : code;

  assign date_today = (dom == {3'b0, cfg.today_day}) &&
                      (in_rec.month == {4'b0, cfg.today_month});
  assign date_tom   = (dom == {3'b0, cfg.next_day}) &&
                      (in_rec.month == {4'b0, cfg.next_month});

  always_comb begin
    hit_today = 1'b0;
    hit_tom   = 1'b0;
    if (code == sdfs_pkg::DAILY_CODE) begin
      hit_today = 1'b1;
    end else if (weekly) begin
      hit_today = ({1'b0, wd} == wd_today);
      hit_tom   = ({1'b0, wd} == wd_tom);
    end else begin
      hit_today = date_today;
      hit_tom   = date_tom;
    end
  end

  assign active   = in_rec.flags != cfg.inactive_code;
  assign slot_ext = SW'(in_rec.slot);

  assign sts.end_scan = (slot_ext >= SW'(MAX_SLOTS)) || (in_rec.flags == cfg.end_code);
  assign sts.m_today  = active && hit_today;
  assign sts.m_tom    = active && hit_tom && (in_rec.flags == cfg.remind_code);
  assign sts.last     = in_last || (slot_ext + SW'(1) == SW'(MAX_SLOTS));
  assign sts.rec_tom  = rec_tom_r;
  assign sts.rec_last = rec_last_r;
  assign sts.full     = count_r == CW'(MAX_KEPT);

  assign swap = (cur_r.tomorrow && !rdata_r.tomorrow) ||
                ((cur_r.tomorrow == rdata_r.tomorrow) &&
                 (sdfs_pkg::minutes(cur_r.hour, cur_r.minute) >
                  sdfs_pkg::minutes(rdata_r.hour, rdata_r.minute)));

  always_comb begin
    we    = 1'b0;
    waddr = wr_addr;
    wdata = cur_r;
    if (cmd.wr_today) begin
      we    = 1'b1;
      waddr = count_r[AW-1:0];
      wdata = '{hour: in_rec.hour, minute: in_rec.minute, tomorrow: 1'b0,
                flags: in_rec.flags, category: in_rec.category,
                subject: in_rec.subject, slot: in_rec.slot};
    end else if (cmd.wr_tom) begin
      we    = 1'b1;
      waddr = count_r[AW-1:0];
      wdata = '{hour: rec_r.hour, minute: rec_r.minute, tomorrow: 1'b1,
                flags: rec_r.flags, category: rec_r.category,
                subject: rec_r.subject, slot: rec_r.slot};
    end else if (cmd.cmp_step) begin
      we = swap;
    end else if (cmd.wb) begin
      we = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_clr) begin
      count_nxt = '0;
    end else if (cmd.wr_today || cmd.wr_tom) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_load) begin
      rec_r      <= in_rec;
      rec_tom_r  <= sts.m_tom;
      rec_last_r <= sts.last;
    end
    if (cmd.cur_load || (cmd.cmp_step && swap)) begin
      cur_r <= rdata_r;
    end
    if (cmd.out_load) begin
      out_entry_r <= rdata_r;
      out_empty_r <= 1'b0;
      out_last_r  <= cmd.out_last;
    end else if (cmd.out_empty) begin
      out_entry_r <= '0;
      out_empty_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign kept_count = count_r;
  assign out_entry  = out_entry_r;
  assign out_empty  = out_empty_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/sdfs_ctrl.sv =====
`timescale 1ns / 1ps

module sdfs_ctrl #(
  parameter int MAX_KEPT = sdfs_pkg::MAX_KEPT_DEF,
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  localparam int CW = $clog2(MAX_KEPT + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  sdfs_pkg::sts_t  sts,
  input  logic [CW-1:0]   kept_count,
  output sdfs_pkg::cmd_t  cmd,
  output logic [AW-1:0]   rd_addr,
  output logic [AW-1:0]   wr_addr
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOM,
    S_SORT,
    S_LD_RD,
    S_LD_CAP,
    S_CMP_RD,
    S_CMP,
    S_WB,
    S_EM_RD,
    S_EM_LOAD,
    S_EM_WAIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          in_tready_r;
  logic          out_tvalid_r;
  logic          k_last;

  assign k_last = (k_r + CW'(1)) == kept_count;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    rd_addr   = i_r[AW-1:0];
    wr_addr   = i_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          if (sts.end_scan) begin
            state_nxt = S_SORT;
          end else begin
            cmd.rec_load = 1'b1;
            cmd.wr_today = sts.m_today && !sts.full;
            state_nxt    = S_TOM;
          end
        end
      end
      S_TOM: begin
        cmd.wr_tom = sts.rec_tom && !sts.full;
        state_nxt  = sts.rec_last ? S_SORT : S_IDLE;
      end
      S_SORT: begin
        i_nxt = '0;
        k_nxt = '0;
        state_nxt = (kept_count >= CW'(2)) ? S_LD_RD : S_EM_RD;
      end
      S_LD_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LD_CAP;
      end
      S_LD_CAP: begin
        cmd.cur_load = 1'b1;
        j_nxt        = i_r + CW'(1);
        state_nxt    = S_CMP_RD;
      end
      S_CMP_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = j_r[AW-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        wr_addr      = j_r[AW-1:0];
        j_nxt        = j_r + CW'(1);
        state_nxt    = ((j_r + CW'(1)) == kept_count) ? S_WB : S_CMP_RD;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        i_nxt  = i_r + CW'(1);
        if (({1'b0, i_r} + (CW+1)'(2)) == {1'b0, kept_count}) begin
          k_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_LD_RD;
        end
      end
      S_EM_RD: begin
        rd_addr = k_r[AW-1:0];
        if (kept_count == '0) begin
          cmd.out_empty = 1'b1;
          state_nxt     = S_EM_WAIT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EM_LOAD;
        end
      end
      S_EM_LOAD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = k_last;
        state_nxt    = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (out_tready) begin
          if (k_last || kept_count == '0) begin
            cmd.count_clr = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      in_tready_r  <= state_nxt == S_IDLE;
      out_tvalid_r <= state_nxt == S_EM_WAIT;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

// ===== verif/schedule_day_filter_sort_checker.sv =====
`timescale 1ns / 1ps

module schedule_day_filter_sort_checker #(
  parameter int MAX_KEPT  = sdfs_pkg::MAX_KEPT_DEF,
  parameter int MAX_SLOTS = sdfs_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [sdfs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sdfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [sdfs_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                             out_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdfs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sdfs_pkg::CFG_DATA_W-1:0]  pwdata,
  input  logic                             pready,
  output int                               pending,
  output int                               mismatches,
  output int                               lists_done
);

  typedef struct {
    sdfs_pkg::entry_t e;
    logic             empty;
    logic             last;
  } list_item_t;

  sdfs_pkg::cfg_t   day_cfg;
  sdfs_pkg::entry_t kept [MAX_KEPT];
  int               kept_n;
  list_item_t       due_list [$];

  function automatic void keep_entry(sdfs_pkg::record_t r, logic tom);
    if (kept_n < MAX_KEPT) begin
      kept[kept_n].hour     = r.hour;
      kept[kept_n].minute   = r.minute;
      kept[kept_n].tomorrow = tom;
      kept[kept_n].flags    = r.flags;
      kept[kept_n].category = r.category;
      kept[kept_n].subject  = r.subject;
      kept[kept_n].slot     = r.slot;
      kept_n++;
    end
  endfunction

  function automatic int clock_minutes(sdfs_pkg::entry_t e);
    return int'(e.hour) * int'(sdfs_pkg::MIN_PER_HOUR) + int'(e.minute);
  endfunction

  function automatic void emit_day_list();
    sdfs_pkg::entry_t tmp;
    list_item_t       li;
    for (int i = 0; i + 1 < kept_n; i++) begin
      for (int j = i + 1; j < kept_n; j++) begin
        if (kept[i].tomorrow > kept[j].tomorrow ||
            (kept[i].tomorrow == kept[j].tomorrow &&
             clock_minutes(kept[i]) > clock_minutes(kept[j]))) begin
          tmp     = kept[i];
          kept[i] = kept[j];
          kept[j] = tmp;
        end
      end
    end
    if (kept_n == 0) begin
      li.e     = '0;
      li.empty = 1'b1;
      li.last  = 1'b1;
      due_list.push_back(li);
    end else begin
      for (int k = 0; k < kept_n; k++) begin
        li.e     = kept[k];
        li.empty = 1'b0;
        li.last  = (k == kept_n - 1);
        due_list.push_back(li);
      end
    end
    kept_n = 0;
  endfunction

  function automatic void filter_record(sdfs_pkg::record_t r, logic fin);
    logic hit_today;
    logic hit_next;
    logic scan_end;
    int   wd_code;
    int   day_no;
    hit_today = 1'b0;
    hit_next  = 1'b0;
    scan_end  = fin || (int'(r.slot) + 1 == MAX_SLOTS);
    if (int'(r.slot) >= MAX_SLOTS || r.flags == day_cfg.end_code) begin
      emit_day_list();
      return;
    end
    if (r.flags != day_cfg.inactive_code) begin
      if (r.day_code == sdfs_pkg::DAILY_CODE) begin
        hit_today = 1'b1;
      end else if (r.day_code inside {[sdfs_pkg::WEEKLY_LO:sdfs_pkg::WEEKLY_HI]}) begin
        wd_code   = int'(r.day_code) - int'(sdfs_pkg::WEEKLY_BASE);
        hit_today = wd_code == int'(day_cfg.today_weekday) + 1;
        hit_next  = wd_code == (int'(day_cfg.today_weekday) + 1) %
                               int'(sdfs_pkg::DAYS_IN_WEEK) + 1;
      end else begin
        day_no = (r.day_code inside {[sdfs_pkg::YEARLY_LO:sdfs_pkg::YEARLY_HI]}) ?
                 int'(r.day_code) - int'(sdfs_pkg::YEARLY_BASE) : int'(r.day_code);
        hit_today = day_no == int'(day_cfg.today_day) &&
                    int'(r.month) == int'(day_cfg.today_month);
        hit_next  = day_no == int'(day_cfg.next_day) &&
                    int'(r.month) == int'(day_cfg.next_month);
      end
      if (hit_today) keep_entry(r, 1'b0);
      if (hit_next && r.flags == day_cfg.remind_code) keep_entry(r, 1'b1);
    end
    if (scan_end) emit_day_list();
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    list_item_t head;
    if (!rst_n) begin
      day_cfg.today_day     = sdfs_pkg::TODAY_DAY_RST;
      day_cfg.today_month   = sdfs_pkg::TODAY_MONTH_RST;
      day_cfg.today_weekday = sdfs_pkg::TODAY_WEEKDAY_RST;
      day_cfg.next_day      = sdfs_pkg::NEXT_DAY_RST;
      day_cfg.next_month    = sdfs_pkg::NEXT_MONTH_RST;
      day_cfg.end_code      = sdfs_pkg::END_CODE_RST;
      day_cfg.inactive_code = sdfs_pkg::INACTIVE_CODE_RST;
      day_cfg.remind_code   = sdfs_pkg::REMIND_CODE_RST;
      kept_n     = 0;
      mismatches = 0;
      lists_done = 0;
      due_list.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (sdfs_pkg::reg_idx_t'(paddr[sdfs_pkg::CFG_ADDR_W-1:2]))
          sdfs_pkg::REG_TODAY_DAY:     day_cfg.today_day     = pwdata[4:0];
          sdfs_pkg::REG_TODAY_MONTH:   day_cfg.today_month   = pwdata[3:0];
          sdfs_pkg::REG_TODAY_WEEKDAY: day_cfg.today_weekday = pwdata[2:0];
          sdfs_pkg::REG_NEXT_DAY:      day_cfg.next_day      = pwdata[4:0];
          sdfs_pkg::REG_NEXT_MONTH:    day_cfg.next_month    = pwdata[3:0];
          sdfs_pkg::REG_END_CODE:      day_cfg.end_code      = pwdata[7:0];
          sdfs_pkg::REG_INACTIVE_CODE: day_cfg.inactive_code = pwdata[7:0];
          sdfs_pkg::REG_REMIND_CODE:   day_cfg.remind_code   = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_list.size() == 0) begin
          $error("list entry with none due: tdata %h tuser %b", out_tdata, out_tuser);
          mismatches++;
        end else begin
          head = due_list.pop_front();
          check_field("out_hour", head.e.hour, out_tdata[7:0]);
          check_field("out_minute", head.e.minute, out_tdata[15:8]);
          check_field("out_flags", head.e.flags, out_tdata[23:16]);
          check_field("out_category", head.e.category, out_tdata[31:24]);
          check_field("out_subject", head.e.subject, out_tdata[39:32]);
          check_field("out_slot", 8'(head.e.slot), 8'(out_tdata[45:40]));
          check_field("is_tomorrow", 8'(head.e.tomorrow), 8'(out_tuser[0]));
          check_field("list_empty", 8'(head.empty), 8'(out_tuser[1]));
          check_field("last_of_list", 8'(head.last), 8'(out_tlast));
          if (head.last) lists_done++;
        end
      end
      if (in_tvalid && in_tready)
        filter_record(sdfs_pkg::record_t'(in_tdata[$bits(sdfs_pkg::record_t)-1:0]),
                      in_tlast);
    end
    pending <= due_list.size();
  end

endmodule

// ===== verif/schedule_day_filter_sort_core_tb.sv =====
`timescale 1ns / 1ps

module schedule_day_filter_sort_core_tb;

  localparam int IDLE_LIMIT     = 4000;
  localparam int RANDOM_RECORDS = 270;
  localparam int LONG_HOLD      = 400;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_mode_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [sdfs_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tlast   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [sdfs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [sdfs_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tlast;
  logic                             psel       = 1'b0;
  logic                             penable    = 1'b0;
  logic                             pwrite     = 1'b0;
  logic [sdfs_pkg::CFG_ADDR_W-1:0]  paddr      = '0;
  logic [sdfs_pkg::CFG_DATA_W-1:0]  pwdata     = '0;
  logic [sdfs_pkg::CFG_DATA_W-1:0]  prdata;
  logic                             pready;

  int             pending;
  int             mismatches;
  int             lists_done;
  sdfs_pkg::cfg_t cur_cfg;
  logic           hold_phase     = 1'b0;
  logic           hold_armed     = 1'b1;
  int             hold_left      = 0;
  sink_mode_t     sink_mode      = SINK_OPEN;
  int             span_left      = 0;
  int             idle_cycles    = 0;
  int             burst_left     = 0;
  int             records_sent   = 0;
  int             settings_used  = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  schedule_day_filter_sort_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  schedule_day_filter_sort_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .mismatches (mismatches),
    .lists_done (lists_done)
  );

  // hold off for a long stretch each time a pressure phase starts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_armed <= 1'b1;
      span_left  <= 0;
    end else if (hold_phase && hold_armed) begin
      hold_armed <= 1'b0;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (!hold_phase) hold_armed <= 1'b1;
      if (span_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 2));
        span_left <= $urandom_range(1, 40);
      end else begin
        span_left <= span_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:   out_tready <= 1'b1;
        SINK_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        default:     out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(sdfs_pkg::reg_idx_t idx, logic [31:0] value, int width);
    logic [31:0] noise;
    noise = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom << width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value | noise;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(sdfs_pkg::cfg_t c);
    cur_cfg = c;
    write_reg(sdfs_pkg::REG_TODAY_DAY, 32'(c.today_day), 5);
    write_reg(sdfs_pkg::REG_TODAY_MONTH, 32'(c.today_month), 4);
    write_reg(sdfs_pkg::REG_TODAY_WEEKDAY, 32'(c.today_weekday), 3);
    write_reg(sdfs_pkg::REG_NEXT_DAY, 32'(c.next_day), 5);
    write_reg(sdfs_pkg::REG_NEXT_MONTH, 32'(c.next_month), 4);
    write_reg(sdfs_pkg::REG_END_CODE, 32'(c.end_code), 8);
    write_reg(sdfs_pkg::REG_INACTIVE_CODE, 32'(c.inactive_code), 8);
    write_reg(sdfs_pkg::REG_REMIND_CODE, 32'(c.remind_code), 8);
    settings_used++;
  endtask

  task automatic send_record(sdfs_pkg::record_t r, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= sdfs_pkg::IN_TDATA_W'(r);
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    records_sent++;
  endtask

  // stop offering and wait out every list still due, then let the block settle
  task automatic drain_lists();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic sdfs_pkg::record_t schedule_record(logic [7:0] hour,
                                                        logic [7:0] minute,
                                                        logic [7:0] code,
                                                        logic [7:0] month,
                                                        logic [7:0] flags,
                                                        logic [5:0] slot);
    sdfs_pkg::record_t r;
    r.hour     = hour;
    r.minute   = minute;
    r.day_code = code;
    r.month    = month;
    r.category = 8'($urandom);
    r.flags    = flags;
    r.subject  = 8'($urandom);
    r.slot     = slot;
    return r;
  endfunction

  function automatic logic [7:0] pick_day();
    case ($urandom_range(0, 2))
      0:       return 8'(cur_cfg.today_day);
      1:       return 8'(cur_cfg.next_day);
      default: return 8'($urandom_range(1, 31));
    endcase
  endfunction

  function automatic sdfs_pkg::record_t random_record();
    sdfs_pkg::record_t r;
    int                roll;
    r.hour     = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.minute   = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    r.category = 8'($urandom);
    r.subject  = 8'($urandom);
    r.slot     = 6'($urandom_range(0, sdfs_pkg::MAX_SLOTS_DEF - 2));
    case ($urandom_range(0, 3))
      0:       r.month = 8'($urandom);
      1:       r.month = 8'(cur_cfg.next_month);
      default: r.month = 8'(cur_cfg.today_month);
    endcase
    case ($urandom_range(0, 3))
      0:       r.day_code = sdfs_pkg::DAILY_CODE;
      1:       r.day_code = 8'($urandom_range(sdfs_pkg::WEEKLY_LO, sdfs_pkg::WEEKLY_HI));
      2:       r.day_code = sdfs_pkg::YEARLY_BASE + pick_day();
      default: r.day_code = ($urandom_range(0, 2) == 0) ? 8'($urandom) : pick_day();
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 35)      r.flags = cur_cfg.remind_code;
    else if (roll < 45) r.flags = cur_cfg.inactive_code;
    else                r.flags = 8'($urandom);
    return r;
  endfunction

  task automatic random_scan(int len);
    sdfs_pkg::record_t r;
    int                ending;
    logic              fin;
    for (int k = 0; k < len; k++) begin
      r   = random_record();
      fin = 1'b0;
      if (k + 1 == len) begin
        ending = $urandom_range(0, 9);
        fin    = (ending < 7) || (ending == 9 && $urandom_range(0, 1) == 1);
        if (ending == 7 || ending == 8) r.flags = cur_cfg.end_code;
        if (ending == 9) r.slot = 6'(sdfs_pkg::MAX_SLOTS_DEF - 1);
      end
      send_record(r, fin);
    end
  endtask

  function automatic sdfs_pkg::cfg_t pick_setting(int ph);
    sdfs_pkg::cfg_t c;
    c.today_day     = 5'($urandom_range(1, 31));
    c.today_month   = 4'($urandom_range(1, 12));
    c.today_weekday = 3'($urandom_range(0, 6));
    if ($urandom_range(0, 4) == 0) begin
      c.next_day   = c.today_day;
      c.next_month = c.today_month;
    end else begin
      c.next_day   = 5'($urandom_range(1, 31));
      c.next_month = 4'($urandom_range(1, 12));
    end
    c.end_code      = 8'($urandom);
    c.inactive_code = 8'($urandom);
    c.remind_code   = 8'($urandom);
    case (ph)
      0: begin
        c.today_day     = 5'd31;
        c.today_month   = 4'd12;
        c.today_weekday = 3'd6;
        c.next_day      = 5'd1;
        c.next_month    = 4'd1;
        c.end_code      = 8'd0;
        c.inactive_code = 8'd255;
        c.remind_code   = 8'd128;
      end
      1: begin
        c.today_day     = 5'd0;
        c.today_month   = 4'd15;
        c.today_weekday = 3'd7;
        c.next_day      = 5'd31;
        c.next_month    = 4'd12;
        c.end_code      = 8'd254;
        c.inactive_code = 8'd1;
        c.remind_code   = 8'd255;
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    sdfs_pkg::cfg_t c;
    int             n_scans;
    int             len;
    cur_cfg.today_day     = sdfs_pkg::TODAY_DAY_RST;
    cur_cfg.today_month   = sdfs_pkg::TODAY_MONTH_RST;
    cur_cfg.today_weekday = sdfs_pkg::TODAY_WEEKDAY_RST;
    cur_cfg.next_day      = sdfs_pkg::NEXT_DAY_RST;
    cur_cfg.next_month    = sdfs_pkg::NEXT_MONTH_RST;
    cur_cfg.end_code      = sdfs_pkg::END_CODE_RST;
    cur_cfg.inactive_code = sdfs_pkg::INACTIVE_CODE_RST;
    cur_cfg.remind_code   = sdfs_pkg::REMIND_CODE_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_record(schedule_record(8'd9, 8'd0, sdfs_pkg::DAILY_CODE, 8'd0,
                                sdfs_pkg::END_CODE_RST, 6'd0), 1'b0);

    send_record(schedule_record(8'd255, 8'd255, sdfs_pkg::DAILY_CODE, 8'd0, 8'd2, 6'd0),
                1'b0);
    send_record(schedule_record(8'd0, 8'd0, sdfs_pkg::DAILY_CODE, 8'd0, 8'd1, 6'd1), 1'b0);
    send_record(schedule_record(8'd7, 8'd30, sdfs_pkg::WEEKLY_LO, 8'd0, 8'd5, 6'd2), 1'b0);
    send_record(schedule_record(8'd6, 8'd0, sdfs_pkg::WEEKLY_LO + 8'd1, 8'd0, 8'd2, 6'd3),
                1'b0);
    send_record(schedule_record(8'd5, 8'd0, sdfs_pkg::WEEKLY_HI, 8'd0, 8'd2, 6'd4), 1'b0);
    send_record(schedule_record(8'd7, 8'd30, sdfs_pkg::YEARLY_LO, 8'd1, 8'd3, 6'd5), 1'b0);
    send_record(schedule_record(8'd0, 8'd0, sdfs_pkg::YEARLY_LO + 8'd1, 8'd1, 8'd2, 6'd6),
                1'b0);
    send_record(schedule_record(8'd1, 8'd1, sdfs_pkg::YEARLY_HI, 8'd255, 8'd2, 6'd7), 1'b0);
    send_record(schedule_record(8'd12, 8'd0, 8'd1, 8'd1, 8'd2, 6'd8), 1'b0);
    send_record(schedule_record(8'd6, 8'd0, 8'd2, 8'd1, 8'd2, 6'd9), 1'b0);
    send_record(schedule_record(8'd3, 8'd3, sdfs_pkg::DAILY_CODE, 8'd0,
                                sdfs_pkg::INACTIVE_CODE_RST, 6'd10), 1'b1);

    send_record(schedule_record(8'd23, 8'd59, sdfs_pkg::DAILY_CODE, 8'd0, 8'd7, 6'd62),
                1'b0);
    send_record(schedule_record(8'd1, 8'd0, sdfs_pkg::DAILY_CODE, 8'd0,
                                sdfs_pkg::INACTIVE_CODE_RST, 6'd63), 1'b0);

    // today equals tomorrow: each yearly record keeps two entries until the store fills
    drain_lists();
    c.today_day     = 5'd5;
    c.today_month   = 4'd3;
    c.today_weekday = 3'd6;
    c.next_day      = 5'd5;
    c.next_month    = 4'd3;
    c.end_code      = 8'd77;
    c.inactive_code = 8'd77;
    c.remind_code   = 8'd200;
    apply_setting(c);
    send_record(schedule_record(8'd12, 8'd0, sdfs_pkg::DAILY_CODE, 8'd0, 8'd9, 6'd0), 1'b0);
    for (int k = 1; k <= 8; k++)
      send_record(schedule_record(8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)),
                                  sdfs_pkg::YEARLY_BASE + 8'd5, 8'd3, 8'd200, 6'(k)),
                  1'b0);
    send_record(schedule_record(8'd0, 8'd0, sdfs_pkg::DAILY_CODE, 8'd0, 8'd77, 6'd9), 1'b0);

    for (int ph = 0; records_sent < RANDOM_RECORDS; ph++) begin
      drain_lists();
      apply_setting(pick_setting(ph));
      if (ph == 2) begin
        hold_phase <= 1'b1;
        for (int s = 0; s < 3; s++) random_scan(8);
        hold_phase <= 1'b0;
      end else begin
        n_scans = $urandom_range(1, 4);
        for (int s = 0; s < n_scans; s++) begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 10);
          random_scan(len);
        end
      end
    end

    drain_lists();
    repeat (20) @(posedge clk);
    $display("%0d schedule records sent under %0d register settings", records_sent,
             settings_used);
    $display("%0d day lists compared, incl. empty, full-store and long output stall",
             lists_done);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
